FILE: rtl/dphd_pkg.sv
package dphd_pkg;

    // Field widths of the words on the channels.
    localparam int PAD_IDX_W  = 4;
    localparam int SAMPLE_W   = 12;
    localparam int TIME_W     = 32;
    localparam int HOLDOFF_W  = 16;
    localparam int NOTE_W     = 7;
    localparam int VEL_W      = 7;
    localparam int NOTE_TAB_W = 56;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 56;

    // Number of pads served, default for the top-level parameter.
    localparam int PADS_DEF = 16;

    // Register defaults after reset.
    localparam logic [SAMPLE_W-1:0]   THRESH_RST    = 12'd1550;
    localparam logic [HOLDOFF_W-1:0]  HOLDOFF_RST   = 16'd75;
    localparam logic [NOTE_TAB_W-1:0] NOTE_LOW_RST  = 56'd21578237090600484;
    localparam logic [NOTE_TAB_W-1:0] NOTE_HIGH_RST = 56'd5038;

    // Velocity scaling: (sample - 75) * 127 / 4020, floor, clamped to 127.
    localparam int VEL_OFFSET      = 75;
    localparam int VEL_SCALE       = 127;
    localparam int VEL_SPAN        = 4020;
    localparam int VEL_MAX         = 127;
    localparam int VEL_P_W         = 19;
    localparam int VEL_RECIP_SHIFT = 32;
    localparam int VEL_RECIP_W     = 21;
    localparam longint unsigned VEL_RECIP = (64'd1 << VEL_RECIP_SHIFT) / VEL_SPAN;
    localparam int VEL_PROD_W      = VEL_P_W + VEL_RECIP_W;
    localparam int VEL_Q_W         = 8;

    // Depth of the hit queue between the detector and the result stage.
    localparam int FIFO_DEPTH = 4;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESHOLD = 2'd0,
        CFG_HOLDOFF   = 2'd1,
        CFG_NOTE_LOW  = 2'd2,
        CFG_NOTE_HIGH = 2'd3
    } t_cfg_idx;

    // Register contents handed to the detector.
    typedef struct packed {
        logic [SAMPLE_W-1:0]   threshold;
        logic [HOLDOFF_W-1:0]  holdoff;
        logic [NOTE_TAB_W-1:0] note_low;
        logic [NOTE_TAB_W-1:0] note_high;
    } t_cfg;

    // One detected hit: the pad's note and the falling sample after the peak.
    typedef struct packed {
        logic [NOTE_W-1:0]   note;
        logic [SAMPLE_W-1:0] sample;
    } t_hit;

endpackage

FILE: rtl/dphd_if.sv
interface dphd_in_if;
    import dphd_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [PAD_IDX_W-1:0] pad_index;
    logic [SAMPLE_W-1:0]  sample;
    logic [TIME_W-1:0]    time_ms;

    modport source (output valid, pad_index, sample, time_ms, input ready);
    modport sink   (input valid, pad_index, sample, time_ms, output ready);
endinterface

interface dphd_out_if;
    import dphd_pkg::*;
    logic              valid;
    logic              ready;
    logic              is_note_off;
    logic [NOTE_W-1:0] note;
    logic [VEL_W-1:0]  velocity;
    logic              last;

    modport source (output valid, is_note_off, note, velocity, last, input ready);
    modport sink   (input valid, is_note_off, note, velocity, last, output ready);
endinterface

interface dphd_cfg_if;
    import dphd_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/dphd_front.sv
module dphd_front #(
    parameter int PADS = dphd_pkg::PADS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  dphd_pkg::t_cfg i_cfg_regs,
    dphd_in_if.sink        i_in,
    output logic           o_push_valid,
    output dphd_pkg::t_hit o_push_data,
    input  logic           i_push_ready
);
    import dphd_pkg::*;

    localparam int PAD_W = (PADS > 1) ? $clog2(PADS) : 1;

    logic                 r_armed [PADS];
    logic [SAMPLE_W-1:0]  r_prev  [PADS];
    logic [TIME_W-1:0]    r_time  [PADS];

    logic                 acc;
    logic                 in_range;
    logic [PAD_W-1:0]     idx;
    logic [SAMPLE_W-1:0]  prev;
    logic                 was_armed;
    logic [TIME_W-1:0]    since;
    logic                 arm;
    logic                 fire;
    logic [NOTE_TAB_W-1:0] tab;
    logic [5:0]           base;

    // A word is taken whenever the hit queue has room.
    assign i_in.ready = i_push_ready;
    assign acc        = i_in.valid && i_push_ready;
    assign in_range   = 32'(i_in.pad_index) < PADS;
    assign idx        = i_in.pad_index[PAD_W-1:0];

    // Look up the addressed pad and classify the sample.
    always_comb begin
        prev      = r_prev[idx];
        was_armed = r_armed[idx];
        since     = i_in.time_ms - r_time[idx];
        arm       = (i_in.sample > prev) && (i_in.sample > i_cfg_regs.threshold)
                    && (since > TIME_W'(i_cfg_regs.holdoff));
        fire      = was_armed && (i_in.sample < prev);
    end

    // Note of the pad: seven bits per pad, eight pads per table word.
    always_comb begin
        tab  = i_in.pad_index[3] ? i_cfg_regs.note_high : i_cfg_regs.note_low;
        base = 6'(i_in.pad_index[2:0]) * 6'd7;
    end

    assign o_push_valid       = i_in.valid && in_range && fire;
    assign o_push_data.note   = tab[base +: NOTE_W];
    assign o_push_data.sample = i_in.sample;

    // Per-pad state update: arming, disarming after the peak, last sample.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < PADS; i++) begin
                r_armed[i] <= 1'b0;
                r_prev[i]  <= '0;
                r_time[i]  <= '0;
            end
        end else if (acc && in_range) begin
            if (arm) begin
                r_armed[idx] <= 1'b1;
                r_time[idx]  <= i_in.time_ms;
            end else if (fire) begin
                r_armed[idx] <= 1'b0;
            end
            r_prev[idx] <= i_in.sample;
        end
    end

`ifndef SYNTH
    // A pad that gave a hit is disarmed afterwards.
    a_fire_disarms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push_valid && i_push_ready) |=> !r_armed[$past(idx)])
        else $error("pad still armed after its hit");
`endif

endmodule

FILE: rtl/dphd_fifo.sv
module dphd_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push_valid,
    input  dphd_pkg::t_hit i_push_data,
    output logic           o_push_ready,
    output logic           o_pop_valid,
    output dphd_pkg::t_hit o_pop_data,
    input  logic           i_pop_ready
);
    import dphd_pkg::*;

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    t_hit             r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic             push;
    logic             pop;

    assign o_push_ready = r_count != CNT_W'(FIFO_DEPTH);
    assign o_pop_valid  = r_count != '0;
    assign o_pop_data   = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    // Pointers wrap at the queue depth.
    always_comb begin
        n_wr_ptr = (r_wr_ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        n_rd_ptr = (r_rd_ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
    end

    // Storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

`ifndef SYNTH
    // The fill count follows pushes and pops.
    a_count_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("fill count lost a push");
`endif

endmodule

FILE: rtl/dphd_back.sv
module dphd_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_pop_valid,
    input  dphd_pkg::t_hit i_pop_data,
    output logic           o_pop_ready,
    dphd_out_if.source     o_out
);
    import dphd_pkg::*;

    logic                    r_s1_valid;
    logic [NOTE_W-1:0]       r_s1_note;
    logic [VEL_P_W-1:0]      r_s1_p;
    logic                    r_s2_valid;
    logic [NOTE_W-1:0]       r_s2_note;
    logic [VEL_P_W-1:0]      r_s2_p;
    logic [VEL_Q_W-1:0]      r_s2_q;
    logic                    r_out_valid;
    logic                    r_phase;
    logic [NOTE_W-1:0]       r_note;
    logic [VEL_W-1:0]        r_vel;

    logic [SAMPLE_W-1:0]     x;
    logic [VEL_P_W-1:0]      p;
    logic [VEL_PROD_W-1:0]   prod;
    logic [VEL_P_W-1:0]      rem;
    logic [VEL_Q_W-1:0]      q;
    logic [VEL_W-1:0]        vel;
    logic                    out_take;
    logic                    s2_take;
    logic                    s1_take;
    logic                    pop;

    // Stage handshake: a stage loads when it is empty or passes its word on.
    assign out_take    = !r_out_valid || (o_out.ready && r_phase);
    assign s2_take     = !r_s2_valid || out_take;
    assign s1_take     = !r_s1_valid || s2_take;
    assign o_pop_ready = s1_take;
    assign pop         = i_pop_valid && s1_take;

    // Stage 1 input: scaled height above the offset.
    always_comb begin
        x = (i_pop_data.sample > SAMPLE_W'(VEL_OFFSET))
            ? i_pop_data.sample - SAMPLE_W'(VEL_OFFSET) : '0;
        p = VEL_P_W'(x) * VEL_P_W'(VEL_SCALE);
    end

    // Stage 2 input: quotient estimate by reciprocal, at most one too small.
    assign prod = VEL_PROD_W'(r_s1_p) * VEL_PROD_W'(VEL_RECIP_W'(VEL_RECIP));

    // Output stage input: remainder check and clamp.
    always_comb begin
        rem = r_s2_p - VEL_P_W'(r_s2_q) * VEL_P_W'(VEL_SPAN);
        q   = (rem >= VEL_P_W'(VEL_SPAN)) ? r_s2_q + 1'b1 : r_s2_q;
        vel = (q > VEL_Q_W'(VEL_MAX)) ? VEL_W'(VEL_MAX) : q[VEL_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= 1'b0;
        end else begin
            if (s1_take) begin
                r_s1_valid <= i_pop_valid;
            end
            if (s2_take) begin
                r_s2_valid <= r_s1_valid;
            end
            // Note-on taken: show the note-off of the same hit next.
            if (r_out_valid && o_out.ready && !r_phase) begin
                r_phase <= 1'b1;
            end else if (out_take) begin
                r_out_valid <= r_s2_valid;
                r_phase     <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_s1_note <= i_pop_data.note;
            r_s1_p    <= p;
        end
        if (s2_take && r_s1_valid) begin
            r_s2_note <= r_s1_note;
            r_s2_p    <= r_s1_p;
            r_s2_q    <= prod[VEL_RECIP_SHIFT +: VEL_Q_W];
        end
        if (out_take && r_s2_valid) begin
            r_note <= r_s2_note;
            r_vel  <= vel;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.is_note_off = r_phase;
    assign o_out.note        = r_note;
    assign o_out.velocity    = r_phase ? '0 : r_vel;
    assign o_out.last        = r_phase;

`ifndef SYNTH
    // Every taken note-on is followed by the note-off of the same note.
    a_off_follows_on: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready && !r_phase) |=>
        (o_out.valid && r_phase && $stable(r_note)))
        else $error("note-off missing after note-on");

    // A word popped from the queue lands in stage 1.
    a_pop_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |=> r_s1_valid)
        else $error("popped hit dropped");

    // A stage 2 word is held while the output stage cannot take it.
    a_s2_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_valid && !out_take) |=> (r_s2_valid && $stable(r_s2_p)))
        else $error("stage 2 word lost under stall");
`endif

endmodule

FILE: rtl/drum_pad_hit_detector.sv
// Channel   Dir  Carries
// --------  ---  ------------------------------------------------------------
// i_in      in   pad_index, sample, time_ms: one converter reading of one pad
// o_out     out  is_note_off, note, velocity, last: note-on or note-off word
// i_cfg     in   index, data: register write (threshold, holdoff, note tables)
//
// The detector takes one input word per cycle while the four-entry hit queue
// has room; per-pad state is read and written in that same cycle.
// A queued hit reaches o_out through two velocity stages and the output register
// and holds the output for two words, note-on then note-off, while later hits
// wait in the stages and the queue behind it.
// Reset is synchronous and clears all pad state, the queue and the pipeline at once.
// A stalled output backs up the pipeline, then the queue, then i_in.ready.
module drum_pad_hit_detector #(
    parameter int PADS = dphd_pkg::PADS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dphd_in_if.sink    i_in,
    dphd_out_if.source o_out,
    dphd_cfg_if.sink   i_cfg
);
    import dphd_pkg::*;

    t_cfg r_cfg;
    logic push_valid;
    logic push_ready;
    t_hit push_data;
    logic pop_valid;
    logic pop_ready;
    t_hit pop_data;

    // Register writes are always taken.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.threshold <= THRESH_RST;
            r_cfg.holdoff   <= HOLDOFF_RST;
            r_cfg.note_low  <= NOTE_LOW_RST;
            r_cfg.note_high <= NOTE_HIGH_RST;
        end else if (i_cfg.valid) begin
            unique case (t_cfg_idx'(i_cfg.index))
                CFG_THRESHOLD: r_cfg.threshold <= i_cfg.data[SAMPLE_W-1:0];
                CFG_HOLDOFF:   r_cfg.holdoff   <= i_cfg.data[HOLDOFF_W-1:0];
                CFG_NOTE_LOW:  r_cfg.note_low  <= i_cfg.data[NOTE_TAB_W-1:0];
                CFG_NOTE_HIGH: r_cfg.note_high <= i_cfg.data[NOTE_TAB_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Peak detection per pad.
    dphd_front #(
        .PADS(PADS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_regs   (r_cfg),
        .i_in         (i_in),
        .o_push_valid (push_valid),
        .o_push_data  (push_data),
        .i_push_ready (push_ready)
    );

    // Hit queue.
    dphd_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .i_push_data  (push_data),
        .o_push_ready (push_ready),
        .o_pop_valid  (pop_valid),
        .o_pop_data   (pop_data),
        .i_pop_ready  (pop_ready)
    );

    // Velocity and note-on / note-off words.
    dphd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (pop_valid),
        .i_pop_data  (pop_data),
        .o_pop_ready (pop_ready),
        .o_out       (o_out)
    );

endmodule

FILE: sim/drum_pad_hit_checker.sv
// Watches the sample, note and register channels of the hit detector, predicts
// the note words from its own copy of the pad state and compares them in order.
module drum_pad_hit_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    dphd_in_if   i_in,
    dphd_out_if  i_out,
    dphd_cfg_if  i_cfg,
    output int   o_fail_count,
    output int   o_pending
);
    import dphd_pkg::*;

    localparam int unsigned VEL_FLOOR   = 75;
    localparam int unsigned VEL_GAIN    = 127;
    localparam int unsigned VEL_RANGE   = 4020;
    localparam int unsigned VEL_CEILING = 127;

    typedef struct packed {
        logic              is_note_off;
        logic [NOTE_W-1:0] note;
        logic [VEL_W-1:0]  velocity;
        logic              last;
    } t_note_word;

    // Register shadows.
    logic [SAMPLE_W-1:0]   threshold;
    logic [HOLDOFF_W-1:0]  holdoff;
    logic [NOTE_TAB_W-1:0] notes_low;
    logic [NOTE_TAB_W-1:0] notes_high;

    // Per-pad peak tracking state.
    logic                armed_pad [PADS_DEF];
    logic [SAMPLE_W-1:0] prev_sample [PADS_DEF];
    logic [TIME_W-1:0]   trigger_time [PADS_DEF];

    t_note_word expected_notes[$];
    int         mismatches;

    // Velocity of a note-on: offset, scale and clamp of the falling sample.
    function automatic logic [VEL_W-1:0] strike_velocity(input logic [SAMPLE_W-1:0] smp);
        int unsigned v;
        if (smp <= VEL_FLOOR) begin
            return '0;
        end
        v = (int'(smp) - VEL_FLOOR) * VEL_GAIN / VEL_RANGE;
        if (v > VEL_CEILING) begin
            v = VEL_CEILING;
        end
        return v[VEL_W-1:0];
    endfunction

    // MIDI note of a pad, seven bits per pad in the low or high table.
    function automatic logic [NOTE_W-1:0] pad_note(input logic [PAD_IDX_W-1:0] pad);
        logic [NOTE_TAB_W-1:0] tab;
        tab = (pad < 8) ? notes_low : notes_high;
        return NOTE_W'(tab >> (NOTE_W * int'(pad[2:0])));
    endfunction

    task automatic compare_field(input string name, input int unsigned want,
                                 input int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : track
        t_note_word           got;
        t_note_word           want;
        logic [PAD_IDX_W-1:0] pad;
        logic [SAMPLE_W-1:0]  smp;
        logic [TIME_W-1:0]    stamp;
        logic [TIME_W-1:0]    elapsed;
        logic [NOTE_W-1:0]    pad_midi;
        if (!i_rst_n) begin
            threshold  = THRESH_RST;
            holdoff    = HOLDOFF_RST;
            notes_low  = NOTE_LOW_RST;
            notes_high = NOTE_HIGH_RST;
            for (int p = 0; p < PADS_DEF; p++) begin
                armed_pad[p]    = 1'b0;
                prev_sample[p]  = '0;
                trigger_time[p] = '0;
            end
            expected_notes.delete();
            mismatches = 0;
        end else begin
            // Compare each accepted note word with the oldest prediction.
            if (i_out.valid && i_out.ready) begin
                got = '{is_note_off: i_out.is_note_off, note: i_out.note,
                        velocity: i_out.velocity, last: i_out.last};
                if (expected_notes.size() == 0) begin
                    $error("unexpected note word: off %0d note %0d velocity %0d last %0d",
                           got.is_note_off, got.note, got.velocity, got.last);
                    mismatches++;
                end else begin
                    want = expected_notes.pop_front();
                    compare_field("is_note_off", want.is_note_off, got.is_note_off);
                    compare_field("note", want.note, got.note);
                    compare_field("velocity", want.velocity, got.velocity);
                    compare_field("last", want.last, got.last);
                end
            end

            // Register writes.
            if (i_cfg.valid && i_cfg.ready) begin
                case (t_cfg_idx'(i_cfg.index))
                    CFG_THRESHOLD: threshold  = i_cfg.data[SAMPLE_W-1:0];
                    CFG_HOLDOFF:   holdoff    = i_cfg.data[HOLDOFF_W-1:0];
                    CFG_NOTE_LOW:  notes_low  = i_cfg.data[NOTE_TAB_W-1:0];
                    CFG_NOTE_HIGH: notes_high = i_cfg.data[NOTE_TAB_W-1:0];
                    default: ;
                endcase
            end

            // Arm on a rising sample past threshold and holdoff, fire after the peak.
            if (i_in.valid && i_in.ready) begin
                pad   = i_in.pad_index;
                smp   = i_in.sample;
                stamp = i_in.time_ms;
                if (int'(pad) < PADS_DEF) begin
                    elapsed = stamp - trigger_time[pad];
                    if (smp > prev_sample[pad] && smp > threshold &&
                        elapsed > TIME_W'(holdoff)) begin
                        armed_pad[pad]    = 1'b1;
                        trigger_time[pad] = stamp;
                    end
                    if (armed_pad[pad] && smp < prev_sample[pad]) begin
                        pad_midi = pad_note(pad);
                        expected_notes.push_back('{is_note_off: 1'b0, note: pad_midi,
                                                   velocity: strike_velocity(smp),
                                                   last: 1'b0});
                        expected_notes.push_back('{is_note_off: 1'b1, note: pad_midi,
                                                   velocity: '0, last: 1'b1});
                        armed_pad[pad] = 1'b0;
                    end
                    prev_sample[pad] = smp;
                end
            end
        end
        o_pending    <= expected_notes.size();
        o_fail_count <= mismatches;
    end

endmodule

FILE: sim/tb_drum_pad_hit_detector.sv
module tb_drum_pad_hit_detector;
    import dphd_pkg::*;

    localparam int SETTLE_CYCLES = 12;
    localparam int LONG_HOLD     = 400;
    localparam int STUCK_LIMIT   = 4000;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;

    dphd_in_if  in_ch ();
    dphd_out_if out_ch ();
    dphd_cfg_if cfg_ch ();

    drum_pad_hit_detector i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    drum_pad_hit_checker i_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .i_cfg        (cfg_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Stimulus state: per-pad stroke envelope and the running clock.
    int          stroke_level [16];
    bit          stroke_rising [16];
    logic [31:0] now_ms;
    bit          src_steady;
    bit          sink_steady;
    int          hold_requests;
    int          stuck_cycles;

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Next sample of a pad's stroke: climbs in random steps, peaks, then decays.
    function automatic logic [11:0] next_stroke(input int pad);
        if (stroke_rising[pad]) begin
            stroke_level[pad] += $urandom_range(0, 900);
            if (stroke_level[pad] >= 4095) begin
                stroke_level[pad]  = 4095;
                stroke_rising[pad] = 1'b0;
            end else if ($urandom_range(0, 3) == 0) begin
                stroke_rising[pad] = 1'b0;
            end
        end else begin
            stroke_level[pad] -= $urandom_range(0, 900);
            if (stroke_level[pad] <= 0) begin
                stroke_level[pad]  = 0;
                stroke_rising[pad] = 1'b1;
            end else if ($urandom_range(0, 2) == 0) begin
                stroke_rising[pad] = 1'b1;
            end
        end
        return 12'(stroke_level[pad]);
    endfunction

    function automatic logic [NOTE_TAB_W-1:0] random_notes();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[NOTE_TAB_W-1:0];
    endfunction

    // Offer one sample word after a random gap and wait until it is taken.
    task automatic send_sample(input logic [3:0] pad, input logic [11:0] smp,
                               input logic [31:0] stamp);
        int gap;
        if ($urandom_range(0, 39) == 0) begin
            src_steady = !src_steady;
        end
        gap = src_steady ? 0 : $urandom_range(0, 12);
        repeat (gap) begin
            @(negedge clk);
            in_ch.valid <= 1'b0;
        end
        @(negedge clk);
        in_ch.valid     <= 1'b1;
        in_ch.pad_index <= pad;
        in_ch.sample    <= smp;
        in_ch.time_ms   <= stamp;
        do begin
            @(posedge clk);
        end while (!in_ch.ready);
    endtask

    // Stop offering samples until every predicted note word has come out.
    task automatic wait_for_results();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (pending != 0) begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        wait_for_results();
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do begin
            @(posedge clk);
        end while (!cfg_ch.ready);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Mostly well-formed strokes on random pads, some fully random words.
    task automatic random_items(input int count);
        logic [3:0] pad;
        repeat (count) begin
            pad = 4'($urandom_range(0, 15));
            if ($urandom_range(0, 99) < 12) begin
                send_sample(pad, 12'($urandom), $urandom);
            end else begin
                now_ms += $urandom_range(0, 40);
                send_sample(pad, next_stroke(pad), now_ms);
            end
        end
    endtask

    // Note sink: random stalls per word, steady stretches, one long hold-off on request.
    initial begin : note_sink
        int stall;
        int holds_done;
        holds_done   = 0;
        sink_steady  = 1'b0;
        out_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            if (hold_requests > holds_done) begin
                holds_done++;
                repeat (LONG_HOLD) begin
                    @(negedge clk);
                    out_ch.ready <= 1'b0;
                end
            end
            if ($urandom_range(0, 39) == 0) begin
                sink_steady = !sink_steady;
            end
            stall = sink_steady ? 0 : $urandom_range(0, 12);
            repeat (stall) begin
                @(negedge clk);
                out_ch.ready <= 1'b0;
            end
            @(negedge clk);
            out_ch.ready <= 1'b1;
            do begin
                @(posedge clk);
            end while (!out_ch.valid);
        end
    end

    // Watchdog: the run is stuck when no word moves on any channel for too long.
    always @(posedge clk) begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready)) begin
            stuck_cycles <= 0;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
        if (stuck_cycles == STUCK_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin : stimulus
        rst_n           = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.pad_index = '0;
        in_ch.sample    = '0;
        in_ch.time_ms   = '0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.index    = CFG_THRESHOLD;
        cfg_ch.data     = '0;
        src_steady      = 1'b0;
        hold_requests   = 0;
        now_ms          = 32'h400;
        for (int p = 0; p < 16; p++) begin
            stroke_level[p]  = 0;
            stroke_rising[p] = 1'b1;
        end
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Arm, a rise inside the holdoff, then the peak with near-full velocity.
        send_sample(4'd0, 12'd2000, 32'd1000);
        send_sample(4'd0, 12'd4095, 32'd1001);
        send_sample(4'd0, 12'd4094, 32'd1002);
        // Highest pad, fired with a zero sample.
        send_sample(4'd15, 12'd4095, 32'd1100);
        send_sample(4'd15, 12'd0, 32'd1101);
        // Rise blocked by the holdoff, so the following fall gives nothing.
        send_sample(4'd0, 12'd4095, 32'd1003);
        send_sample(4'd0, 12'd100, 32'd1004);
        // A flat sample neither fires nor disarms.
        send_sample(4'd1, 12'd3000, 32'd2000);
        send_sample(4'd1, 12'd3000, 32'd2001);
        send_sample(4'd1, 12'd2999, 32'd2002);
        // A sample equal to the threshold does not arm.
        send_sample(4'd2, 12'd1550, 32'd2000);
        send_sample(4'd2, 12'd1549, 32'd2001);
        // Timestamp wrap: holdoff measured across the wrap.
        send_sample(4'd3, 12'd3000, 32'hFFFF_FFF0);
        send_sample(4'd3, 12'd100, 32'hFFFF_FFF8);
        send_sample(4'd3, 12'd3500, 32'h0000_0020);
        send_sample(4'd3, 12'd0, 32'h0000_0021);
        send_sample(4'd3, 12'd4000, 32'h0000_0100);
        send_sample(4'd3, 12'd80, 32'h0000_0101);
        send_sample(4'd9, 12'd4095, 32'h0000_0200);
        send_sample(4'd9, 12'd2000, 32'h0000_0201);
        // Threshold below the velocity offset: a low peak gives velocity zero.
        write_reg(CFG_THRESHOLD, 56'd10);
        send_sample(4'd4, 12'd60, 32'h0000_0300);
        send_sample(4'd4, 12'd20, 32'h0000_0301);

        // Default settings, with a long sink hold-off and a full drain in between.
        write_reg(CFG_THRESHOLD, 56'(THRESH_RST));
        random_items(150);
        hold_requests++;
        random_items(120);
        wait_for_results();
        random_items(130);

        // Lowest threshold and holdoff, extreme note tables.
        write_reg(CFG_THRESHOLD, 56'd0);
        write_reg(CFG_HOLDOFF, 56'd0);
        write_reg(CFG_NOTE_LOW, '1);
        write_reg(CFG_NOTE_HIGH, '0);
        random_items(300);

        // Highest threshold and holdoff, then a reachable threshold.
        write_reg(CFG_THRESHOLD, 56'hFFF);
        write_reg(CFG_HOLDOFF, 56'hFFFF);
        write_reg(CFG_NOTE_LOW, '0);
        write_reg(CFG_NOTE_HIGH, '1);
        random_items(50);
        write_reg(CFG_THRESHOLD, 56'd2000);
        random_items(50);

        // Threshold under the velocity offset, short holdoff, random notes.
        write_reg(CFG_THRESHOLD, 56'd40);
        write_reg(CFG_HOLDOFF, 56'd20);
        write_reg(CFG_NOTE_LOW, random_notes());
        write_reg(CFG_NOTE_HIGH, random_notes());
        random_items(300);

        // Random settings with the clock running through its wrap.
        now_ms = 32'hFFFF_F000;
        write_reg(CFG_THRESHOLD, 56'($urandom_range(0, 4095)));
        write_reg(CFG_HOLDOFF, 56'($urandom_range(0, 200)));
        write_reg(CFG_NOTE_LOW, random_notes());
        write_reg(CFG_NOTE_HIGH, random_notes());
        random_items(500);

        // Back to the reset settings.
        write_reg(CFG_THRESHOLD, 56'(THRESH_RST));
        write_reg(CFG_HOLDOFF, 56'(HOLDOFF_RST));
        write_reg(CFG_NOTE_LOW, NOTE_LOW_RST);
        write_reg(CFG_NOTE_HIGH, NOTE_HIGH_RST);
        random_items(350);

        wait_for_results();
        if (fail_count == 0 && pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/dphd_pkg.sv
rtl/dphd_if.sv
rtl/dphd_front.sv
rtl/dphd_fifo.sv
rtl/dphd_back.sv
rtl/drum_pad_hit_detector.sv
sim/drum_pad_hit_checker.sv
sim/tb_drum_pad_hit_detector.sv
